// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/hfr_pkg.sv -----
// ----------------------------------------------------------------------------
// hfr_pkg
// Shared widths, codes and types of the handshake frame receiver.
// ----------------------------------------------------------------------------
package hfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int FREE_W      = 13;
    localparam int INDEX_W     = 9;
    localparam int PHASE_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int BUFFER_BYTES = 4096;

    localparam logic [PHASE_W-1:0] PH_SEND_INIT     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT_INIT_ACK = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SEND_REQ      = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT_DATA     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SEND_FIN      = 3'd4;
    localparam logic [PHASE_W-1:0] PH_WAIT_FIN_ACK  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_ERROR         = 3'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_INIT     = 3'd0,
        CFG_CODE_INIT_ACK = 3'd1,
        CFG_CODE_DATA_REQ = 3'd2,
        CFG_CODE_FIN      = 3'd3,
        CFG_CODE_FIN_ACK  = 3'd4
    } t_cfg_idx;

    localparam logic [BYTE_W-1:0] CODE_INIT_RST     = 8'd1;
    localparam logic [BYTE_W-1:0] CODE_INIT_ACK_RST = 8'd2;
    localparam logic [BYTE_W-1:0] CODE_DATA_REQ_RST = 8'd3;
    localparam logic [BYTE_W-1:0] CODE_FIN_RST      = 8'd4;
    localparam logic [BYTE_W-1:0] CODE_FIN_ACK_RST  = 8'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] init;
        logic [BYTE_W-1:0] init_reply;
        logic [BYTE_W-1:0] data_poll;
        logic [BYTE_W-1:0] fin;
        logic [BYTE_W-1:0] fin_ack;
    } t_codes;

    typedef struct packed {
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              tx_ready;
        logic [FREE_W-1:0] free_bytes;
    } t_item;

    typedef struct packed {
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               rec_valid;
        logic [BYTE_W-1:0]  rec_byte;
        logic [INDEX_W-1:0] rec_index;
        logic               rec_commit;
        logic               rec_abort;
        logic               stream_done;
        logic [PHASE_W-1:0] phase;
    } t_result;

endpackage

// ----- design/hfr_if.sv -----
// ----------------------------------------------------------------------------
// hfr_if
// Valid/ready channels of the receiver: link step input, result output and
// register write port.
// ----------------------------------------------------------------------------
interface hfr_in_if import hfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic              tx_ready;
    logic [FREE_W-1:0] free_bytes;

    modport source (output valid, rx_valid, rx_byte, tx_ready, free_bytes, input ready);
    modport sink   (input valid, rx_valid, rx_byte, tx_ready, free_bytes, output ready);
endinterface

interface hfr_out_if import hfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               rec_valid;
    logic [BYTE_W-1:0]  rec_byte;
    logic [INDEX_W-1:0] rec_index;
    logic               rec_commit;
    logic               rec_abort;
    logic               stream_done;
    logic [PHASE_W-1:0] phase;

    modport source (output valid, tx_valid, tx_byte, rec_valid, rec_byte, rec_index,
                    rec_commit, rec_abort, stream_done, phase, input ready);
    modport sink   (input valid, tx_valid, tx_byte, rec_valid, rec_byte, rec_index,
                    rec_commit, rec_abort, stream_done, phase, output ready);
endinterface

interface hfr_cfg_if import hfr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/hfr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hfr_cfg_regs
// Handshake symbol code registers, written through the register port.
// ----------------------------------------------------------------------------
module hfr_cfg_regs import hfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hfr_cfg_if.sink   i_cfg,
    output t_codes    o_codes
);

    t_codes r_codes;

    assign i_cfg.ready = 1'b1;
    assign o_codes     = r_codes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.init       <= CODE_INIT_RST;
            r_codes.init_reply <= CODE_INIT_ACK_RST;
            r_codes.data_poll  <= CODE_DATA_REQ_RST;
            r_codes.fin        <= CODE_FIN_RST;
            r_codes.fin_ack    <= CODE_FIN_ACK_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CODE_INIT:     r_codes.init       <= i_cfg.data;
                CFG_CODE_INIT_ACK: r_codes.init_reply <= i_cfg.data;
                CFG_CODE_DATA_REQ: r_codes.data_poll  <= i_cfg.data;
                CFG_CODE_FIN:      r_codes.fin        <= i_cfg.data;
                CFG_CODE_FIN_ACK:  r_codes.fin_ack    <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ----- design/hfr_core.sv -----
// ----------------------------------------------------------------------------
// hfr_core
// Link phase and record assembly state; computes the result of one step.
// ----------------------------------------------------------------------------
module hfr_core import hfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_codes  i_codes,
    output t_result o_result
);

    typedef enum logic [PHASE_W-1:0] {
        S_SEND_INIT     = PH_SEND_INIT,
        S_WAIT_INIT_ACK = PH_WAIT_INIT_ACK,
        S_SEND_REQ      = PH_SEND_REQ,
        S_WAIT_DATA     = PH_WAIT_DATA,
        S_SEND_FIN      = PH_SEND_FIN,
        S_WAIT_FIN_ACK  = PH_WAIT_FIN_ACK,
        S_ERROR         = PH_ERROR
    } t_link_state;

    typedef enum logic [1:0] {
        AS_EMPTY    = 2'd0,
        AS_LOADING  = 2'd1,
        AS_COMPLETE = 2'd2
    } t_asm_state;

    t_link_state        r_link, n_link;
    t_asm_state         r_asm, n_asm;
    logic [BYTE_W-1:0]  r_len, n_len;
    logic [INDEX_W-1:0] r_cnt, n_cnt;
    logic [INDEX_W-1:0] r_tot, n_tot;

    logic               stored;
    logic               fits;
    logic [BYTE_W-1:0]  len_mid;
    logic [INDEX_W-1:0] tot_mid;
    logic [INDEX_W-1:0] cnt_base;
    logic [INDEX_W-1:0] cnt_mid;
    t_result            res;

    assign o_result = res;

    always_comb begin
        n_link   = r_link;
        n_asm    = r_asm;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_tot    = r_tot;
        res      = '0;
        res.phase = PHASE_W'(r_link);
        stored   = 1'b0;
        len_mid  = r_len;
        tot_mid  = r_tot;
        cnt_base = r_cnt;
        cnt_mid  = r_cnt;
        fits     = 1'b0;
        unique case (r_link)
            S_SEND_INIT: begin
                if (i_item.tx_ready) begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = i_codes.init;
                    n_link       = S_WAIT_INIT_ACK;
                end
            end
            S_WAIT_INIT_ACK: begin
                if (i_item.rx_valid) begin
                    n_link = (i_item.rx_byte == i_codes.init_reply) ? S_SEND_REQ : S_ERROR;
                end
            end
            S_SEND_REQ: begin
                if (i_item.tx_ready) begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = i_codes.data_poll;
                    n_link       = S_WAIT_DATA;
                end
            end
            S_WAIT_DATA: begin
                if (i_item.rx_valid) begin
                    unique case (r_asm)
                        AS_EMPTY: begin
                            len_mid  = i_item.rx_byte;
                            tot_mid  = INDEX_W'(i_item.rx_byte) + INDEX_W'(2);
                            cnt_base = '0;
                            n_asm    = AS_LOADING;
                            stored   = 1'b1;
                        end
                        AS_LOADING: stored = 1'b1;
                        default:    stored = 1'b0;
                    endcase
                    cnt_mid = stored ? cnt_base + INDEX_W'(1) : cnt_base;
                    if (stored) begin
                        res.rec_valid = 1'b1;
                        res.rec_byte  = i_item.rx_byte;
                        res.rec_index = cnt_base;
                    end
                    n_len  = len_mid;
                    n_tot  = tot_mid;
                    n_cnt  = cnt_mid;
                    n_link = stored ? S_SEND_REQ : S_ERROR;
                    fits   = (FREE_W'(len_mid) + FREE_W'(2) <= i_item.free_bytes) &&
                             ((32'(len_mid) + 32'd2) <= BUFFER_BYTES);
                    if (cnt_mid == tot_mid) begin
                        n_asm = AS_COMPLETE;
                        if (fits) begin
                            n_asm          = AS_EMPTY;
                            n_len          = '0;
                            n_cnt          = '0;
                            n_tot          = '0;
                            res.rec_commit = 1'b1;
                            n_link         = S_SEND_FIN;
                        end
                    end
                end
            end
            S_SEND_FIN: begin
                if (i_item.tx_ready) begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = i_codes.fin;
                    n_link       = S_WAIT_FIN_ACK;
                end
            end
            S_WAIT_FIN_ACK: begin
                if (i_item.rx_valid) begin
                    if (i_item.rx_byte == i_codes.fin_ack) begin
                        res.stream_done = 1'b1;
                        n_link          = S_SEND_INIT;
                    end else begin
                        n_link = S_ERROR;
                    end
                end
            end
            default: begin
                res.rec_abort = (r_asm != AS_EMPTY);
                n_asm  = AS_EMPTY;
                n_len  = '0;
                n_cnt  = '0;
                n_tot  = '0;
                n_link = S_SEND_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= S_SEND_INIT;
            r_asm  <= AS_EMPTY;
            r_len  <= '0;
            r_cnt  <= '0;
            r_tot  <= '0;
        end else if (i_step) begin
            r_link <= n_link;
            r_asm  <= n_asm;
            r_len  <= n_len;
            r_cnt  <= n_cnt;
            r_tot  <= n_tot;
        end
    end

endmodule

// ----- design/hfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// hfr_out_stage
// Result register; takes a new result whenever empty or being drained.
// ----------------------------------------------------------------------------
module hfr_out_stage import hfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_result   i_result,
    output logic      o_space,
    hfr_out_if.source o_out
);

    logic    r_valid;
    t_result r_result;

    assign o_space = !r_valid || o_out.ready;

    assign o_out.valid       = r_valid;
    assign o_out.tx_valid    = r_result.tx_valid;
    assign o_out.tx_byte     = r_result.tx_byte;
    assign o_out.rec_valid   = r_result.rec_valid;
    assign o_out.rec_byte    = r_result.rec_byte;
    assign o_out.rec_index   = r_result.rec_index;
    assign o_out.rec_commit  = r_result.rec_commit;
    assign o_out.rec_abort   = r_result.rec_abort;
    assign o_out.stream_done = r_result.stream_done;
    assign o_out.phase       = r_result.phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- design/handshake_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// handshake_frame_receiver
// Receiving side of a byte handshake over a serial link, with record
// assembly and commit to a downstream buffer.
// ----------------------------------------------------------------------------
// Channels:
//   i_in   one request per link step: rx_valid/rx_byte, tx_ready, free_bytes.
//   o_out  one result per request: transmit byte, forwarded record byte with
//          its index, commit/abort/done flags and the link phase of the step.
//   i_cfg  writes of the five handshake symbol codes; always ready. The user
//          must write them only while no request is in flight; not enforced.
// A result is registered and appears in the cycle after its request is taken.
// Throughput: one request per cycle; the single result register sets this,
//   and i_in.ready is high whenever that register is empty or drained in the
//   same cycle.
// Stall: while o_out.ready is low and a result is held, i_in.ready drops and
//   the result stays unchanged.
// Reset: the link returns to sending INIT, the assembly empties, the codes
//   take their default values and no result is pending.
// ----------------------------------------------------------------------------
module handshake_frame_receiver import hfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hfr_in_if.sink    i_in,
    hfr_out_if.source o_out,
    hfr_cfg_if.sink   i_cfg
);

    t_codes  codes;
    t_item   item;
    t_result result;
    logic    space;
    logic    step;

    assign i_in.ready = space;
    assign step       = i_in.valid && space;

    assign item.rx_valid   = i_in.rx_valid;
    assign item.rx_byte    = i_in.rx_byte;
    assign item.tx_ready   = i_in.tx_ready;
    assign item.free_bytes = i_in.free_bytes;

    hfr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_codes (codes)
    );

    hfr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (item),
        .i_codes  (codes),
        .o_result (result)
    );

    hfr_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (result),
        .o_space  (space),
        .o_out    (o_out)
    );

endmodule

// ----- design/hfr_checker.sv -----
// ----------------------------------------------------------------------------
// hfr_checker
// Port-level checks of the handshake frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hfr_checker import hfr_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    hfr_out_if.source o_out
);

    `ASSERT_CLK(a_done_in_fin_ack, i_clk, i_rst_n, (o_out.valid && o_out.stream_done) |-> (o_out.phase == PH_WAIT_FIN_ACK) && !o_out.rec_valid && !o_out.tx_valid, "stream done outside FIN_ACK wait")
    `ASSERT_CLK(a_abort_in_error, i_clk, i_rst_n, (o_out.valid && o_out.rec_abort) |-> (o_out.phase == PH_ERROR) && !o_out.rec_valid && !o_out.rec_commit, "abort outside error phase")
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, (o_out.valid && !o_out.ready) |=> o_out.valid && $stable(o_out.phase) && $stable(o_out.rec_byte) && $stable(o_out.rec_index) && $stable(o_out.tx_byte), "stalled result changed")
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !o_out.valid, "result pending after reset")

endmodule

bind handshake_frame_receiver hfr_checker u_hfr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_out   (o_out)
);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// handshake_frame_receiver testbench
// Drives link steps through the request channel and checks every result. An
// in-bench link model predicts each step, with its own copy of the link phase,
// the record assembly and the symbol codes. A short directed run covers the
// buffer-full retry, the error phase and ignored inputs. Mostly well-formed
// random exchanges then run under several code settings, with random gaps on
// both channels.
// ----------------------------------------------------------------------------
module testbench;
    import hfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned LONG_HOLD     = 150;
    localparam int unsigned STEPS_PER_SET = 105;
    localparam int unsigned NUM_SETS      = 5;

    typedef enum logic [1:0] {
        ASM_EMPTY    = 2'd0,
        ASM_LOADING  = 2'd1,
        ASM_COMPLETE = 2'd2
    } t_asm_state;

    class record_scoreboard;
        t_codes             codes;
        logic [PHASE_W-1:0] link_phase;
        t_asm_state         asm_state;
        logic [BYTE_W-1:0]  rec_len;
        logic [INDEX_W-1:0] byte_cnt;
        logic [INDEX_W-1:0] rec_total;
        t_result            expected_steps[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        commits;
        int unsigned        aborts;
        int unsigned        exchanges;

        function new();
            codes.init       = CODE_INIT_RST;
            codes.init_reply = CODE_INIT_ACK_RST;
            codes.data_poll  = CODE_DATA_REQ_RST;
            codes.fin        = CODE_FIN_RST;
            codes.fin_ack    = CODE_FIN_ACK_RST;
            link_phase     = PH_SEND_INIT;
            asm_state      = ASM_EMPTY;
            rec_len        = '0;
            byte_cnt       = '0;
            rec_total      = '0;
            mismatches     = 0;
            checked        = 0;
            commits        = 0;
            aborts         = 0;
            exchanges      = 0;
        endfunction

        function void set_code(t_cfg_idx idx, logic [BYTE_W-1:0] v);
            case (idx)
                CFG_CODE_INIT:     codes.init       = v;
                CFG_CODE_INIT_ACK: codes.init_reply = v;
                CFG_CODE_DATA_REQ: codes.data_poll  = v;
                CFG_CODE_FIN:      codes.fin        = v;
                CFG_CODE_FIN_ACK:  codes.fin_ack    = v;
                default: ;
            endcase
        endfunction

        function void clear_record();
            asm_state = ASM_EMPTY;
            rec_len   = '0;
            byte_cnt  = '0;
            rec_total = '0;
        endfunction

        function t_result advance_link(t_item it);
            t_result     r;
            bit          stored;
            int unsigned avail;
            r       = '0;
            r.phase = link_phase;
            case (link_phase)
                PH_SEND_INIT: if (it.tx_ready) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = codes.init;
                    link_phase = PH_WAIT_INIT_ACK;
                end
                PH_WAIT_INIT_ACK: if (it.rx_valid) begin
                    link_phase = (it.rx_byte == codes.init_reply) ? PH_SEND_REQ : PH_ERROR;
                end
                PH_SEND_REQ: if (it.tx_ready) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = codes.data_poll;
                    link_phase = PH_WAIT_DATA;
                end
                PH_WAIT_DATA: if (it.rx_valid) begin
                    stored = 1'b0;
                    if (asm_state == ASM_EMPTY) begin
                        rec_len   = it.rx_byte;
                        rec_total = {1'b0, it.rx_byte} + 9'd2;
                        byte_cnt  = '0;
                        asm_state = ASM_LOADING;
                        stored    = 1'b1;
                    end else if (asm_state == ASM_LOADING) begin
                        stored = 1'b1;
                    end
                    if (stored) begin
                        r.rec_valid = 1'b1;
                        r.rec_byte  = it.rx_byte;
                        r.rec_index = byte_cnt;
                        byte_cnt    = byte_cnt + 1'b1;
                    end
                    link_phase = stored ? PH_SEND_REQ : PH_ERROR;
                    if (byte_cnt == rec_total) begin
                        asm_state = ASM_COMPLETE;
                        avail = (it.free_bytes > BUFFER_BYTES) ? BUFFER_BYTES : it.free_bytes;
                        if (int'(rec_len) + 2 <= avail) begin
                            clear_record();
                            r.rec_commit = 1'b1;
                            link_phase   = PH_SEND_FIN;
                        end
                    end
                end
                PH_SEND_FIN: if (it.tx_ready) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = codes.fin;
                    link_phase = PH_WAIT_FIN_ACK;
                end
                PH_WAIT_FIN_ACK: if (it.rx_valid) begin
                    if (it.rx_byte == codes.fin_ack) begin
                        r.stream_done = 1'b1;
                        link_phase    = PH_SEND_INIT;
                    end else begin
                        link_phase = PH_ERROR;
                    end
                end
                default: begin
                    r.rec_abort = (asm_state != ASM_EMPTY);
                    clear_record();
                    link_phase = PH_SEND_INIT;
                end
            endcase
            return r;
        endfunction

        function bit note_request(t_item it);
            logic [PHASE_W-1:0] prev;
            prev = link_phase;
            expected_steps.push_back(advance_link(it));
            return link_phase != prev;
        endfunction

        function int unsigned pending();
            return expected_steps.size();
        endfunction

        function void flag_field(string name, int unsigned e, int unsigned a);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at result %0d: %s expected %0d got %0d",
                         checked, name, e, a);
        endfunction

        function void check_result(t_result a);
            t_result e;
            if (expected_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request pending: %p", a);
                return;
            end
            e = expected_steps.pop_front();
            checked++;
            commits   += e.rec_commit;
            aborts    += e.rec_abort;
            exchanges += e.stream_done;
            if (a.tx_valid !== e.tx_valid)       flag_field("tx_valid", e.tx_valid, a.tx_valid);
            if (a.tx_byte !== e.tx_byte)         flag_field("tx_byte", e.tx_byte, a.tx_byte);
            if (a.rec_valid !== e.rec_valid)     flag_field("rec_valid", e.rec_valid, a.rec_valid);
            if (a.rec_byte !== e.rec_byte)       flag_field("rec_byte", e.rec_byte, a.rec_byte);
            if (a.rec_index !== e.rec_index)     flag_field("rec_index", e.rec_index, a.rec_index);
            if (a.rec_commit !== e.rec_commit)   flag_field("rec_commit", e.rec_commit, a.rec_commit);
            if (a.rec_abort !== e.rec_abort)     flag_field("rec_abort", e.rec_abort, a.rec_abort);
            if (a.stream_done !== e.stream_done) flag_field("stream_done", e.stream_done, a.stream_done);
            if (a.phase !== e.phase)             flag_field("phase", e.phase, a.phase);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    bit          long_hold_req = 1'b0;
    bit          send_calm = 1'b0;
    int unsigned cycle_count = 0;

    record_scoreboard sb = new();

    hfr_in_if  req_ch ();
    hfr_out_if res_ch ();
    hfr_cfg_if cfg_ch ();

    handshake_frame_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[handshake_frame_receiver] ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_item mk_step(bit rxv, logic [BYTE_W-1:0] rxb, bit txr,
                                      logic [FREE_W-1:0] fr);
        t_item it;
        it.rx_valid   = rxv;
        it.rx_byte    = rxb;
        it.tx_ready   = txr;
        it.free_bytes = fr;
        return it;
    endfunction

    // Bias the next step toward what the current link phase wants.
    function automatic t_item next_step();
        t_item       it;
        int unsigned roll;
        it.rx_valid   = 1'($urandom_range(0, 1));
        it.rx_byte    = BYTE_W'($urandom_range(0, 255));
        it.tx_ready   = 1'($urandom_range(0, 1));
        it.free_bytes = FREE_W'($urandom_range(0, 8191));
        if ($urandom_range(0, 99) < 8)
            return it;
        case (sb.link_phase)
            PH_SEND_INIT, PH_SEND_REQ, PH_SEND_FIN: begin
                it.tx_ready = ($urandom_range(0, 99) < 85);
            end
            PH_WAIT_INIT_ACK: begin
                it.rx_valid = ($urandom_range(0, 99) < 90);
                if ($urandom_range(0, 99) < 95) it.rx_byte = sb.codes.init_reply;
            end
            PH_WAIT_FIN_ACK: begin
                it.rx_valid = ($urandom_range(0, 99) < 90);
                if ($urandom_range(0, 99) < 95) it.rx_byte = sb.codes.fin_ack;
            end
            PH_WAIT_DATA: begin
                it.rx_valid = ($urandom_range(0, 99) < 90);
                if (sb.asm_state == ASM_EMPTY) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 80)      it.rx_byte = BYTE_W'($urandom_range(0, 7));
                    else if (roll < 95) it.rx_byte = BYTE_W'($urandom_range(8, 63));
                    else                it.rx_byte = BYTE_W'($urandom_range(64, 255));
                end
                roll = $urandom_range(0, 99);
                if (roll < 70)      it.free_bytes = FREE_W'($urandom_range(257, 8191));
                else if (roll < 85) it.free_bytes = FREE_W'($urandom_range(0, 12));
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic put_step(t_item it, output bit moved);
        req_ch.valid      <= 1'b1;
        req_ch.rx_valid   <= it.rx_valid;
        req_ch.rx_byte    <= it.rx_byte;
        req_ch.tx_ready   <= it.tx_ready;
        req_ch.free_bytes <= it.free_bytes;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        moved = sb.note_request(it);
    endtask

    task automatic idle_gap();
        int unsigned n;
        n = send_calm ? 0 : pick_gap();
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [BYTE_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.set_code(idx, v);
    endtask

    task automatic load_codes(t_codes c);
        write_reg(CFG_CODE_INIT, c.init);
        write_reg(CFG_CODE_INIT_ACK, c.init_reply);
        write_reg(CFG_CODE_DATA_REQ, c.data_poll);
        write_reg(CFG_CODE_FIN, c.fin);
        write_reg(CFG_CODE_FIN_ACK, c.fin_ack);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        t_result     seen;
        int unsigned hold_left;
        bit          calm;
        hold_left = 0;
        calm      = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                seen.tx_valid    = res_ch.tx_valid;
                seen.tx_byte     = res_ch.tx_byte;
                seen.rec_valid   = res_ch.rec_valid;
                seen.rec_byte    = res_ch.rec_byte;
                seen.rec_index   = res_ch.rec_index;
                seen.rec_commit  = res_ch.rec_commit;
                seen.rec_abort   = res_ch.rec_abort;
                seen.stream_done = res_ch.stream_done;
                seen.phase       = res_ch.phase;
                sb.check_result(seen);
            end
            if (cycle_count % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            if (long_hold_req) begin
                hold_left = LONG_HOLD;
                long_hold_req <= 1'b0;
            end else if (hold_left == 0 && !calm && $urandom_range(0, 99) < 25) begin
                hold_left = pick_gap();
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_codes      code_sets [NUM_SETS];
        bit          moved;
        int unsigned progressed;
        int unsigned sent;
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.rx_valid   <= 1'b0;
        req_ch.rx_byte    <= '0;
        req_ch.tx_ready   <= 1'b0;
        req_ch.free_bytes <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_CODE_INIT;
        cfg_ch.data       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset codes: full buffer then retry, wrong reply, abort, clean finish.
        put_step(mk_step(1'b1, 8'hFF, 1'b0, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h02, 1'b0, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h00, 1'b0, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'hFF, 1'b0, 13'd1), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h5A, 1'b0, 13'h1FFF), moved); idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h02, 1'b0, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b0, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h02, 1'b0, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h00, 1'b0, 13'd4096), moved); idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h11, 1'b0, 13'd1), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h22, 1'b0, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'hA5, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h02, 1'b0, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h00, 1'b0, 13'd2), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'hC3, 1'b0, 13'd2), moved);    idle_gap();
        put_step(mk_step(1'b0, 8'h00, 1'b1, 13'd0), moved);    idle_gap();
        put_step(mk_step(1'b1, 8'h05, 1'b0, 13'd0), moved);    idle_gap();

        code_sets[0] = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        code_sets[1] = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        code_sets[2] = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        for (int s = 3; s < NUM_SETS; s++)
            code_sets[s] = {8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom)};

        sent = 0;
        for (int s = 0; s < NUM_SETS; s++) begin
            drain_results();
            load_codes(code_sets[s]);
            // Stall the result side while requests keep coming.
            if (s == 1) long_hold_req <= 1'b1;
            progressed = 0;
            while (progressed < STEPS_PER_SET) begin
                put_step(next_step(), moved);
                progressed += moved;
                sent++;
                if (sent % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
                idle_gap();
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("checked %0d link steps over %0d code settings", sb.checked, NUM_SETS + 1);
        $display("records committed %0d, aborted %0d, exchanges finished %0d",
                 sb.commits, sb.aborts, sb.exchanges);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[handshake_frame_receiver] OK");
        else
            $display("[handshake_frame_receiver] ERROR");
        $finish;
    end

endmodule
